// File: sv/dcqcn_rc_pkg.sv
// shared types and constants for the dcqcn reaction-point rate controller
`default_nettype none

package dcqcn_rc_pkg;

    // q1.16 fixed point: this value stands for 1.0
    localparam logic [16:0] Q_ONE = 17'd65536;

    // width of the configuration write data and index
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_G         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADDITIVE_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HYPER_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_PERIOD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_PERIOD    = 3'd6;

    // register reset values
    localparam logic [16:0] RST_GAIN_G         = 17'd4096;
    localparam logic [16:0] RST_ADDITIVE_STEP  = 17'd328;
    localparam logic [16:0] RST_HYPER_STEP     = 17'd655;
    localparam logic [31:0] RST_BYTE_THRESHOLD = 32'd10485760;
    localparam logic [7:0]  RST_STAGE_LIMIT    = 8'd5;
    localparam logic [15:0] RST_ALPHA_PERIOD   = 16'd55;
    localparam logic [15:0] RST_RATE_PERIOD    = 16'd55;

    // input op codes
    localparam logic [1:0] OP_PKT_SENT = 2'd0;
    localparam logic [1:0] OP_CNP      = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    // iteration counter ceiling
    localparam logic [7:0] ITER_MAX = 8'd255;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // input word
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] payload_bytes;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [16:0] rate_ratio;
        logic [16:0] target_ratio;
        logic [16:0] alpha_value;
        logic        rate_updated;
    } t_out_word;

    // decoded command kinds
    typedef enum logic [1:0] {
        CMD_PKT  = 2'd0,
        CMD_CNP  = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [15:0] payload_bytes;
    } t_cmd;

    // configuration register set
    typedef struct packed {
        logic [16:0] gain_g;
        logic [16:0] additive_step;
        logic [16:0] hyper_step;
        logic [31:0] byte_threshold;
        logic [7:0]  stage_limit;
        logic [15:0] alpha_period;
        logic [15:0] rate_period;
    } t_cfg;

    // clamp a q1.16 value at one
    function automatic logic [16:0] clamp_one(input logic [16:0] v);
        clamp_one = (v > Q_ONE) ? Q_ONE : v;
    endfunction

    // saturating iteration increment
    function automatic logic [7:0] inc_sat(input logic [7:0] v);
        inc_sat = (v == ITER_MAX) ? ITER_MAX : v + 8'd1;
    endfunction

endpackage

`default_nettype wire

// File: sv/dcqcn_rc_cfg.sv
// configuration register file of the rate controller
`default_nettype none

module dcqcn_rc_cfg (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [dcqcn_rc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [dcqcn_rc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output dcqcn_rc_pkg::t_cfg                    o_cfg
);

    dcqcn_rc_pkg::t_cfg r_cfg;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_g         <= dcqcn_rc_pkg::RST_GAIN_G;
            r_cfg.additive_step  <= dcqcn_rc_pkg::RST_ADDITIVE_STEP;
            r_cfg.hyper_step     <= dcqcn_rc_pkg::RST_HYPER_STEP;
            r_cfg.byte_threshold <= dcqcn_rc_pkg::RST_BYTE_THRESHOLD;
            r_cfg.stage_limit    <= dcqcn_rc_pkg::RST_STAGE_LIMIT;
            r_cfg.alpha_period   <= dcqcn_rc_pkg::RST_ALPHA_PERIOD;
            r_cfg.rate_period    <= dcqcn_rc_pkg::RST_RATE_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dcqcn_rc_pkg::REG_GAIN_G:         r_cfg.gain_g         <= i_cfg_data[16:0];
                dcqcn_rc_pkg::REG_ADDITIVE_STEP:  r_cfg.additive_step  <= i_cfg_data[16:0];
                dcqcn_rc_pkg::REG_HYPER_STEP:     r_cfg.hyper_step     <= i_cfg_data[16:0];
                dcqcn_rc_pkg::REG_BYTE_THRESHOLD: r_cfg.byte_threshold <= i_cfg_data[31:0];
                dcqcn_rc_pkg::REG_STAGE_LIMIT:    r_cfg.stage_limit    <= i_cfg_data[7:0];
                dcqcn_rc_pkg::REG_ALPHA_PERIOD:   r_cfg.alpha_period   <= i_cfg_data[15:0];
                dcqcn_rc_pkg::REG_RATE_PERIOD:    r_cfg.rate_period    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: sv/dcqcn_rc_front.sv
// input side: op decode and the command queue toward the back end
`default_nettype none

module dcqcn_rc_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  dcqcn_rc_pkg::t_in_word  i_in_data,
    output logic                    o_cmd_valid,
    output dcqcn_rc_pkg::t_cmd      o_cmd,
    input  wire                     i_cmd_pop
);

    dcqcn_rc_pkg::t_cmd                     r_q_mem [dcqcn_rc_pkg::Q_DEPTH];
    logic [dcqcn_rc_pkg::Q_PTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [dcqcn_rc_pkg::Q_PTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [dcqcn_rc_pkg::Q_CNT_W-1:0]       r_count;
    dcqcn_rc_pkg::t_cmd                     dec_cmd;
    logic                                   push;
    logic                                   pop;

    // classify the incoming word
    always_comb begin
        dec_cmd.payload_bytes = 16'd0;
        unique case (i_in_data.op)
            dcqcn_rc_pkg::OP_PKT_SENT: begin
                dec_cmd.kind          = dcqcn_rc_pkg::CMD_PKT;
                dec_cmd.payload_bytes = i_in_data.payload_bytes;
            end
            dcqcn_rc_pkg::OP_CNP:  dec_cmd.kind = dcqcn_rc_pkg::CMD_CNP;
            dcqcn_rc_pkg::OP_TICK: dec_cmd.kind = dcqcn_rc_pkg::CMD_TICK;
            default:               dec_cmd.kind = dcqcn_rc_pkg::CMD_NOP;
        endcase
    end

    assign o_in_ready  = (r_count != dcqcn_rc_pkg::Q_CNT_W'(dcqcn_rc_pkg::Q_DEPTH));
    assign push        = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_count != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q_mem[r_rd_ptr];

    // pointer wrap
    always_comb begin
        n_wr_ptr = (r_wr_ptr == dcqcn_rc_pkg::Q_PTR_W'(dcqcn_rc_pkg::Q_DEPTH - 1))
                   ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == dcqcn_rc_pkg::Q_PTR_W'(dcqcn_rc_pkg::Q_DEPTH - 1))
                   ? '0 : r_rd_ptr + 1'b1;
    end

    // queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_mem[r_wr_ptr] <= dec_cmd;
        end
    end

endmodule

`default_nettype wire

// File: sv/dcqcn_rc_back.sv
// back end: rate, target and alpha updates plus the result register
`default_nettype none

module dcqcn_rc_back (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  dcqcn_rc_pkg::t_cfg       i_cfg,
    input  wire                      i_cmd_valid,
    input  dcqcn_rc_pkg::t_cmd       i_cmd,
    output logic                     o_cmd_pop,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output dcqcn_rc_pkg::t_out_word  o_out_data
);

    // controller state
    logic [16:0] r_rate,    n_rate;
    logic [16:0] r_target,  n_target;
    logic [16:0] r_alpha,   n_alpha;
    logic [31:0] r_bytes,   n_bytes;
    logic [7:0]  r_titer,   n_titer;
    logic [7:0]  r_biter,   n_biter;
    logic [15:0] r_acnt,    n_acnt;
    logic        r_aarmed,  n_aarmed;
    logic [15:0] r_rcnt,    n_rcnt;
    logic        upd;
    logic        do_ru;

    // result register
    logic                     r_out_valid;
    dcqcn_rc_pkg::t_out_word  r_out_data;

    // datapath terms
    logic [16:0] g_eff;
    logic [16:0] one_minus_g;
    logic [16:0] cut_factor;
    logic [33:0] alpha_prod;
    logic [33:0] rate_prod;
    logic [16:0] alpha_dec;
    logic [16:0] alpha_cnp;
    logic [16:0] rate_cut;
    logic [32:0] byte_sum;
    logic        byte_hit;
    logic        t_hi;
    logic        b_hi;
    logic [16:0] step;
    logic [17:0] tgt_sum;
    logic [16:0] tgt_new;
    logic [17:0] rate_sum;

    assign o_cmd_pop = i_cmd_valid && (!r_out_valid || i_out_ready);

    // shared multiplies: alpha scaled by (1 - g), rate scaled by (1 - alpha/2)
    always_comb begin
        g_eff       = dcqcn_rc_pkg::clamp_one(i_cfg.gain_g);
        one_minus_g = dcqcn_rc_pkg::Q_ONE - g_eff;
        cut_factor  = dcqcn_rc_pkg::Q_ONE - {1'b0, r_alpha[16:1]};
        alpha_prod  = {17'd0, r_alpha} * {17'd0, one_minus_g};
        rate_prod   = {17'd0, r_rate} * {17'd0, cut_factor};
        alpha_dec   = alpha_prod[32:16];
        alpha_cnp   = alpha_dec + g_eff;
        rate_cut    = rate_prod[32:16];
        byte_sum    = {1'b0, r_bytes} + {17'd0, i_cmd.payload_bytes};
        byte_hit    = (byte_sum >= {1'b0, i_cfg.byte_threshold});
    end

    // per-command state update
    always_comb begin
        n_rate   = r_rate;
        n_target = r_target;
        n_alpha  = r_alpha;
        n_bytes  = r_bytes;
        n_titer  = r_titer;
        n_biter  = r_biter;
        n_acnt   = r_acnt;
        n_aarmed = r_aarmed;
        n_rcnt   = r_rcnt;
        upd      = 1'b0;
        do_ru    = 1'b0;
        t_hi     = 1'b0;
        b_hi     = 1'b0;
        step     = 17'd0;
        tgt_sum  = 18'd0;
        tgt_new  = 17'd0;
        rate_sum = 18'd0;

        unique case (i_cmd.kind)
            dcqcn_rc_pkg::CMD_PKT: begin
                if (byte_hit) begin
                    n_bytes = 32'd0;
                    n_biter = dcqcn_rc_pkg::inc_sat(r_biter);
                    do_ru   = 1'b1;
                end else begin
                    n_bytes = byte_sum[31:0];
                end
            end
            dcqcn_rc_pkg::CMD_CNP: begin
                n_target = r_rate;
                n_rate   = rate_cut;
                n_alpha  = alpha_cnp;
                n_acnt   = i_cfg.alpha_period;
                n_aarmed = 1'b1;
                n_rcnt   = i_cfg.rate_period;
                n_bytes  = 32'd0;
                n_titer  = 8'd0;
                n_biter  = 8'd0;
                upd      = 1'b1;
            end
            dcqcn_rc_pkg::CMD_TICK: begin
                // alpha timer first, then the rate timer
                if (r_aarmed) begin
                    if (r_acnt <= 16'd1) begin
                        n_alpha = alpha_dec;
                        n_acnt  = i_cfg.alpha_period;
                    end else begin
                        n_acnt = r_acnt - 16'd1;
                    end
                end
                if (r_rcnt <= 16'd1) begin
                    n_titer = dcqcn_rc_pkg::inc_sat(r_titer);
                    n_rcnt  = i_cfg.rate_period;
                    do_ru   = 1'b1;
                end else begin
                    n_rcnt = r_rcnt - 16'd1;
                end
            end
            default: begin
            end
        endcase

        // rate update: recovery, additive or hyper increase of the target
        if (do_ru) begin
            t_hi = (n_titer > i_cfg.stage_limit);
            b_hi = (n_biter > i_cfg.stage_limit);
            if (t_hi && b_hi) begin
                step = dcqcn_rc_pkg::clamp_one(i_cfg.hyper_step);
            end else if (t_hi || b_hi) begin
                step = dcqcn_rc_pkg::clamp_one(i_cfg.additive_step);
            end
            tgt_sum  = {1'b0, r_target} + {1'b0, step};
            tgt_new  = (tgt_sum > {1'b0, dcqcn_rc_pkg::Q_ONE}) ? dcqcn_rc_pkg::Q_ONE
                                                                 : tgt_sum[16:0];
            rate_sum = {1'b0, tgt_new} + {1'b0, r_rate};
            n_target = tgt_new;
            n_rate   = rate_sum[17:1];
            upd      = 1'b1;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= dcqcn_rc_pkg::Q_ONE;
            r_target <= dcqcn_rc_pkg::Q_ONE;
            r_alpha  <= dcqcn_rc_pkg::Q_ONE;
            r_bytes  <= 32'd0;
            r_titer  <= 8'd0;
            r_biter  <= 8'd0;
            r_acnt   <= 16'd0;
            r_aarmed <= 1'b0;
            r_rcnt   <= dcqcn_rc_pkg::RST_RATE_PERIOD;
        end else if (o_cmd_pop) begin
            r_rate   <= n_rate;
            r_target <= n_target;
            r_alpha  <= n_alpha;
            r_bytes  <= n_bytes;
            r_titer  <= n_titer;
            r_biter  <= n_biter;
            r_acnt   <= n_acnt;
            r_aarmed <= n_aarmed;
            r_rcnt   <= n_rcnt;
        end
    end

    // result word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result word payload
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_out_data.rate_ratio   <= n_rate;
            r_out_data.target_ratio <= n_target;
            r_out_data.alpha_value  <= n_alpha;
            r_out_data.rate_updated <= upd;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// File: sv/dcqcn_rate_control.sv
// top level of the dcqcn reaction-point rate controller
//
//   port group   dir   handshake              word
//   i_in_*       in    i_in_valid/o_in_ready  t_in_word (op, payload_bytes)
//   o_out_*      out   o_out_valid/i_out_ready t_out_word (rate, target, alpha, flag)
//   i_cfg_*      in    i_cfg_we, no wait      index i_cfg_idx, data i_cfg_data
//
// one word per cycle sustained while i_out_ready drains the result register; an accepted
// word enters the queue, and its pop writes state and result register together (pops wait on stall).
// the update of rate, target and alpha is combinational between the state registers: one 17x17 multiply
// per product, then a truncating shift, so every word sees the previous one's state.
// a two-entry queue parts input and back end; the result register holds under stall.
// synchronous active-low reset brings full rate, alpha one and the rate timer armed.
`default_nettype none

module dcqcn_rate_control (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  dcqcn_rc_pkg::t_in_word                i_in_data,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output dcqcn_rc_pkg::t_out_word               o_out_data,
    input  wire                                   i_cfg_we,
    input  wire  [dcqcn_rc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [dcqcn_rc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    dcqcn_rc_pkg::t_cfg  cfg;
    dcqcn_rc_pkg::t_cmd  cmd;
    logic                cmd_valid;
    logic                cmd_pop;

    // configuration registers
    dcqcn_rc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // decode and queue
    dcqcn_rc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // rate update engine
    dcqcn_rc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
